// ----- sv/sesf_pkg.sv -----
// Shared types, constants and register codes of the Sobel edge stream filter.
`timescale 1ns / 1ps

package sesf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = 12;
  localparam int POS_W      = 11;
  localparam int SUM_W      = 10;
  localparam int SIDE_W     = 12;
  localparam int GRAD_W     = 13;
  localparam int MAG_W      = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [CNT_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [CNT_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [MAG_W-1:0] THRESHOLD_RESET = 13'd153;
  localparam logic [CNT_W-1:0] MIN_DIM         = 12'd3;

  localparam logic [7:0] FLAT_LEVEL = 8'd15;
  localparam logic [7:0] GREY_MAX   = 8'd255;

  // floor(m/3) == (m * 2731) >> 13 for every m below 6144
  localparam int DIV3_PROD_W = 25;
  localparam logic [DIV3_PROD_W-1:0] DIV3_RECIP = 25'd2731;
  localparam int DIV3_SHIFT  = 13;
  localparam int QUOT_W      = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       covered;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0] center_col;
    logic [POS_W-1:0] center_row;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [7:0]       out_alpha;
  } result_t;

  typedef struct packed {
    logic       covered;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } centre_t;

  typedef struct packed {
    logic [SUM_W-1:0] older_sum;
    logic [SUM_W-1:0] prev_sum;
    centre_t          prev_pixel;
  } line_entry_t;

  localparam int ENTRY_W = $bits(line_entry_t);

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] older_sum;
    logic [SUM_W-1:0] prev_sum;
    centre_t          prev_pixel;
  } column_t;

  typedef struct packed {
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    centre_t                  centre;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } gradient_t;

endpackage

// ----- sv/sesf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sesf_window.sv -----
// 3x3 window of grey sums, centre delay line and gradient stage.
`timescale 1ns / 1ps

module sesf_window import sesf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      col_valid,
  input  column_t   col_in,
  output logic      col_ready,
  output logic      grad_valid,
  output gradient_t grad,
  input  logic      grad_ready
);

  // columns 1 and 2 of the window; column 0 is rebuilt from column 1
  logic [SUM_W-1:0] top1, top2, mid1, mid2, bot1, bot2;
  centre_t          dly0;

  logic [SIDE_W-1:0] right_side, left_side, lower_side, upper_side;
  gradient_t         grad_next;
  logic              take;

  assign col_ready = !grad_valid || grad_ready;
  assign take      = col_valid && col_ready;

  always_comb begin
    // window after the shift: s0..s2 top, s3..s5 middle, s6..s8 bottom
    right_side = SIDE_W'(col_in.older_sum) + {1'b0, col_in.prev_sum, 1'b0} +
                 SIDE_W'(col_in.sum);
    left_side  = SIDE_W'(top1) + {1'b0, mid1, 1'b0} + SIDE_W'(bot1);
    lower_side = SIDE_W'(bot1) + {1'b0, bot2, 1'b0} + SIDE_W'(col_in.sum);
    upper_side = SIDE_W'(top1) + {1'b0, top2, 1'b0} + SIDE_W'(col_in.older_sum);
    grad_next.col    = col_in.col;
    grad_next.row    = col_in.row;
    grad_next.centre = dly0;
    grad_next.gx     = $signed({1'b0, right_side}) - $signed({1'b0, left_side});
    grad_next.gy     = $signed({1'b0, lower_side}) - $signed({1'b0, upper_side});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top1 <= '0;
      top2 <= '0;
      mid1 <= '0;
      mid2 <= '0;
      bot1 <= '0;
      bot2 <= '0;
      dly0 <= '0;
    end else if (take) begin
      top1 <= top2;
      top2 <= col_in.older_sum;
      mid1 <= mid2;
      mid2 <= col_in.prev_sum;
      bot1 <= bot2;
      bot2 <= col_in.sum;
      dly0 <= col_in.prev_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (col_ready) begin
      grad_valid <= take && col_in.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && col_in.emit) begin
      grad <= grad_next;
    end
  end

endmodule

// ----- sv/sesf_grade.sv -----
// Magnitude, threshold and grey scaling stages ending in the result register.
`timescale 1ns / 1ps

module sesf_grade import sesf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [MAG_W-1:0] threshold_sum,
  input  logic             grad_valid,
  input  gradient_t        grad,
  output logic             grad_ready,
  output logic             result_valid,
  output result_t          result,
  input  logic             result_ready
);

  logic             mag_valid;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] mag_col, mag_row;
  centre_t          mag_centre;

  logic             mag_ready, out_free;
  logic [MAG_W-1:0] abs_gx, abs_gy;
  logic [DIV3_PROD_W-1:0] prod;
  logic [QUOT_W-1:0]      quot;
  logic [7:0]             grey;
  result_t                result_next;

  assign out_free   = !result_valid || result_ready;
  assign mag_ready  = !mag_valid || out_free;
  assign grad_ready = mag_ready;

  always_comb begin
    abs_gx = grad.gx[GRAD_W-1] ? MAG_W'(-grad.gx) : MAG_W'(grad.gx);
    abs_gy = grad.gy[GRAD_W-1] ? MAG_W'(-grad.gy) : MAG_W'(grad.gy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (mag_ready) begin
      mag_valid <= grad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grad_valid && mag_ready) begin
      mag        <= abs_gx + abs_gy;
      mag_col    <= grad.col;
      mag_row    <= grad.row;
      mag_centre <= grad.centre;
    end
  end

  always_comb begin
    prod = DIV3_PROD_W'(mag) * DIV3_RECIP;
    quot = prod[DIV3_SHIFT +: QUOT_W];
    grey = (quot > QUOT_W'(GREY_MAX)) ? GREY_MAX : quot[7:0];
    result_next.center_col = mag_col;
    result_next.center_row = mag_row;
    if (!mag_centre.covered) begin
      result_next.out_red   = mag_centre.red;
      result_next.out_green = mag_centre.green;
      result_next.out_blue  = mag_centre.blue;
      result_next.out_alpha = mag_centre.alpha;
    end else if (mag < threshold_sum) begin
      result_next.out_red   = FLAT_LEVEL;
      result_next.out_green = FLAT_LEVEL;
      result_next.out_blue  = FLAT_LEVEL;
      result_next.out_alpha = FLAT_LEVEL;
    end else begin
      result_next.out_red   = grey;
      result_next.out_green = grey;
      result_next.out_blue  = grey;
      result_next.out_alpha = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_valid && out_free) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/sobel_edge_stream_filter.sv -----
// Top level of the streaming 3x3 Sobel edge filter with its line buffer.
`timescale 1ns / 1ps

// Usage:
//   pixel channel: one RGBA pixel per transfer in raster order, with a
//   coverage flag and a frame_start flag that marks pixel (0,0).
//   result channel: one transfer per interior centre pixel, carrying its
//   column and row and the replacement colour. Border pixels produce none.
//   cfg port: write width, height or threshold while the stream is idle.
// Throughput: one pixel per clock, sustained while result_ready stays high; the line buffer RAM does one
//   read and one write per cycle.
// Pipeline: a result is registered in turn by the RAM read, gradient, magnitude
//   and output stages after the transfer of the pixel that completes its window.
// Reset: clears the position counters, the window, the centre delay line
//   and the pipeline; the registers return to 640 x 480, threshold 153.
//   Line buffer contents are not cleared; each entry is written before use.
// Stall: when result_ready is low the output register holds; the stages
//   behind it fill and pixel_ready drops once all of them are occupied.

module sobel_edge_stream_filter import sesf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  pixel_t               pixel,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  // configuration
  logic [CNT_W-1:0] image_width, image_height;
  logic [MAG_W-1:0] threshold_sum;
  logic [CNT_W-1:0] width_eff, height_eff;

  // position of the next pixel
  logic [CNT_W-1:0] col_count, row_count;
  logic [CNT_W-1:0] col_cur, row_cur;

  logic              accept;
  logic [ADDR_W-1:0] rd_idx;
  logic [SUM_W-1:0]  sum_cur;
  logic              emit_cur;

  // read stage: pixel waiting for its line buffer entry
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_idx;
  logic [SUM_W-1:0]  s1_sum;
  centre_t           s1_pixel;
  logic              s1_emit;
  logic [POS_W-1:0]  s1_col, s1_row;

  logic        s1_ready, s1_fire;
  logic [ENTRY_W-1:0] rd_data;
  line_entry_t entry, wr_entry;

  // forwarding of a write that lands at the same edge as the read
  logic        fwd_hit;
  line_entry_t fwd_entry;

  column_t   col_item;
  logic      grad_valid, grad_ready;
  gradient_t grad;
  logic      grade_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      threshold_sum <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:     image_width   <= cfg_data[CNT_W-1:0];
        REG_HEIGHT:    image_height  <= cfg_data[CNT_W-1:0];
        REG_THRESHOLD: threshold_sum <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the geometry to what the line buffer and counters hold
  always_comb begin
    if (image_width < MIN_DIM) begin
      width_eff = MIN_DIM;
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height < MIN_DIM) begin
      height_eff = MIN_DIM;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign pixel_ready = s1_ready;
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    col_cur  = pixel.frame_start ? '0 : col_count;
    row_cur  = pixel.frame_start ? '0 : row_count;
    rd_idx   = (32'(col_cur) > MAX_WIDTH - 1) ? ADDR_W'(MAX_WIDTH - 1)
                                               : ADDR_W'(col_cur);
    sum_cur  = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
    emit_cur = (col_cur >= CNT_W'(2)) && (row_cur >= CNT_W'(2)) &&
               (col_cur < width_eff) && (row_cur < height_eff);
  end

  // advance the raster position on each pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_cur >= width_eff - CNT_W'(1)) begin
        col_count <= '0;
        row_count <= (row_cur >= height_eff - CNT_W'(1)) ? '0 : row_cur + CNT_W'(1);
      end else begin
        col_count <= col_cur + CNT_W'(1);
        row_count <= row_cur;
      end
    end
  end

  assign s1_ready = !s1_valid || grad_ready;
  assign s1_fire  = s1_valid && grad_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx   <= rd_idx;
      s1_sum   <= sum_cur;
      s1_pixel <= '{covered: pixel.covered, alpha: pixel.alpha, blue: pixel.blue,
                    green: pixel.green, red: pixel.red};
      s1_emit  <= emit_cur;
      s1_col   <= POS_W'(col_cur - CNT_W'(1));
      s1_row   <= POS_W'(row_cur - CNT_W'(1));
      // the RAM returns the old entry when it is rewritten at this edge
      fwd_hit   <= s1_fire && (rd_idx == s1_idx);
      fwd_entry <= wr_entry;
    end
  end

  // read-modify-write: the previous line sum moves to the older slot
  always_comb begin
    entry               = fwd_hit ? fwd_entry : line_entry_t'(rd_data);
    wr_entry.older_sum  = entry.prev_sum;
    wr_entry.prev_sum   = s1_sum;
    wr_entry.prev_pixel = s1_pixel;
    col_item.emit       = s1_emit;
    col_item.col        = s1_col;
    col_item.row        = s1_row;
    col_item.sum        = s1_sum;
    col_item.older_sum  = entry.older_sum;
    col_item.prev_sum   = entry.prev_sum;
    col_item.prev_pixel = entry.prev_pixel;
  end

  sesf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1_fire),
    .wr_addr(s1_idx),
    .wr_data(wr_entry),
    .rd_en  (accept),
    .rd_addr(rd_idx),
    .rd_data(rd_data)
  );

  sesf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .col_valid (s1_valid),
    .col_in    (col_item),
    .col_ready (grad_ready),
    .grad_valid(grad_valid),
    .grad      (grad),
    .grad_ready(grade_ready)
  );

  sesf_grade u_grade (
    .clk          (clk),
    .rst          (rst),
    .threshold_sum(threshold_sum),
    .grad_valid   (grad_valid),
    .grad         (grad),
    .grad_ready   (grade_ready),
    .result_valid (result_valid),
    .result       (result),
    .result_ready (result_ready)
  );

endmodule
